FILE: rtl/core/fmrb_pkg.sv
// package for the framed message ring buffer
// constants, status codes and the front-to-back command type; no dependencies
package fmrb_pkg;

  localparam int RING_BYTES_DEF   = 1024;
  localparam int HEADER_BYTES_DEF = 8;
  localparam int MAX_MESSAGE_DEF  = 64;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_REJ   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_SMALL = 2'd3;

  localparam logic FUNC_PUT = 1'b0;
  localparam logic FUNC_GET = 1'b1;

  localparam logic [7:0] PAD_BYTE = 8'hFF;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       first;
    logic [9:0] byte_count;
  } cmd_t;

endpackage

FILE: rtl/core/fmrb_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module fmrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/fmrb_front.sv
// front end: two-entry command queue
// depends on fmrb_pkg
module fmrb_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_func,
  input  logic [7:0]          in_data_byte,
  input  logic                in_first_of_message,
  input  logic [9:0]          in_byte_count,
  output logic                q_valid,
  output fmrb_pkg::cmd_t      q_cmd,
  input  logic                q_pop
);

  fmrb_pkg::cmd_t q_r [2];
  logic [1:0]     cnt_r, cnt_nxt;
  logic           rd_r, rd_nxt;
  logic           push;
  fmrb_pkg::cmd_t c;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = q_r[rd_r];

  always_comb begin
    c.func       = in_func;
    c.data_byte  = in_data_byte;
    c.first      = in_first_of_message;
    c.byte_count = in_byte_count;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
    rd_nxt  = rd_r ^ q_pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
    end
    if (push) begin
      q_r[rd_r ^ cnt_r[0]] <= c;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  assert property (@(posedge clk) disable iff (!rst_n) (cnt_r == 2'd0) |-> !q_pop)
    else $error("pop while empty");

endmodule

FILE: rtl/core/fmrb_back.sv
// back end: put/get sequencer over the ring memory with an output register
// depends on fmrb_pkg and fmrb_ram
module fmrb_back #(
  parameter int RING_BYTES   = fmrb_pkg::RING_BYTES_DEF,
  parameter int HEADER_BYTES = fmrb_pkg::HEADER_BYTES_DEF,
  parameter int MAX_MESSAGE  = fmrb_pkg::MAX_MESSAGE_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  fmrb_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [1:0]     out_status,
  output logic [7:0]     out_out_byte,
  output logic           out_byte_valid,
  output logic           out_last
);

  localparam int AW = $clog2(RING_BYTES);
  localparam int HW = $clog2(HEADER_BYTES + 1);
  // wide enough for the free count and for a footprint of a 10-bit length
  localparam int TW = ((AW > 10) ? AW : 10) + 2;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_HDR  = 4'd1;
  localparam logic [3:0] S_PAD  = 4'd2;
  localparam logic [3:0] S_G0   = 4'd3;
  localparam logic [3:0] S_G1   = 4'd4;
  localparam logic [3:0] S_G2   = 4'd5;
  localparam logic [3:0] S_G3   = 4'd6;
  localparam logic [3:0] S_GB   = 4'd7;
  localparam logic [3:0] S_GW   = 4'd8;

  logic [3:0]    st_r, st_nxt;
  logic [AW-1:0] wh_r, wh_nxt, rt_r, rt_nxt, pp_r, pp_nxt;
  logic [6:0]    rem_r, rem_nxt;
  logic          act_r, act_nxt;
  logic          drop_r, drop_nxt;
  logic [HW-1:0] hcnt_r, hcnt_nxt;
  logic [HW-1:0] pad_r, pad_nxt;
  logic [7:0]    len_r, len_nxt, tot_r, tot_nxt;
  logic [7:0]    d0_r, d0_nxt;
  logic [9:0]    cap_r, cap_nxt;
  logic [6:0]    gi_r, gi_nxt;
  logic          ov_r, ov_nxt;
  logic [1:0]    os_r, os_nxt;
  logic [7:0]    ob_r, ob_nxt;
  logic          obv_r, obv_nxt, ol_r, ol_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;

  logic [TW-1:0] tot_c, lenx, used, freeb;
  logic [HW-1:0] padc;
  logic          out_free;
  logic [7:0]    glen;

  fmrb_ram #(.WIDTH(8), .DEPTH(RING_BYTES)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign out_valid      = ov_r;
  assign out_status     = os_r;
  assign out_out_byte   = ob_r;
  assign out_byte_valid = obv_r;
  assign out_last       = ol_r;
  assign out_free       = !ov_r || !out_stall;

  always_comb begin
    lenx  = TW'(q_cmd.byte_count);
    padc  = HW'(HEADER_BYTES - ((HEADER_BYTES + int'(q_cmd.byte_count)) % HEADER_BYTES));
    tot_c = TW'(HEADER_BYTES) + lenx + TW'(padc);
    used  = TW'(AW'(wh_r - rt_r));
    freeb = TW'(RING_BYTES) - used;
    glen  = (rdata > 8'(MAX_MESSAGE)) ? 8'(MAX_MESSAGE) : rdata;
  end

  always_comb begin
    st_nxt = st_r; wh_nxt = wh_r; rt_nxt = rt_r; pp_nxt = pp_r;
    rem_nxt = rem_r; act_nxt = act_r; drop_nxt = drop_r;
    hcnt_nxt = hcnt_r; pad_nxt = pad_r; len_nxt = len_r; tot_nxt = tot_r;
    d0_nxt = d0_r; cap_nxt = cap_r; gi_nxt = gi_r;
    ov_nxt = ov_r && out_stall;
    os_nxt = os_r; ob_nxt = ob_r; obv_nxt = obv_r; ol_nxt = ol_r;
    we = 1'b0; waddr = pp_r; wdata = 8'd0; raddr = rt_r;
    q_pop = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          if (q_cmd.func == fmrb_pkg::FUNC_PUT) begin
            if (q_cmd.first) begin
              act_nxt = 1'b0; rem_nxt = '0; drop_nxt = 1'b0;
              if (q_cmd.byte_count > 10'(MAX_MESSAGE) || tot_c + 1 > freeb) begin
                drop_nxt = 1'b1;
                q_pop = 1'b1;
                ov_nxt = 1'b1; os_nxt = fmrb_pkg::ST_REJ;
                ob_nxt = '0; obv_nxt = 1'b0; ol_nxt = 1'b1;
              end else begin
                // header written byte by byte in S_HDR, item held at queue head
                len_nxt = q_cmd.byte_count[7:0];
                tot_nxt = tot_c[7:0];
                pad_nxt = padc;
                d0_nxt = q_cmd.data_byte;
                pp_nxt = wh_r;
                hcnt_nxt = '0;
                st_nxt = S_HDR;
              end
            end else if (!act_r) begin
              q_pop = 1'b1;
              ov_nxt = 1'b1; os_nxt = fmrb_pkg::ST_REJ;
              ob_nxt = '0; obv_nxt = 1'b0; ol_nxt = 1'b1;
            end else begin
              we = 1'b1; wdata = q_cmd.data_byte;
              pp_nxt = pp_r + 1'b1;
              rem_nxt = rem_r - 1'b1;
              q_pop = 1'b1;
              ov_nxt = 1'b1; os_nxt = fmrb_pkg::ST_OK;
              ob_nxt = '0; obv_nxt = 1'b0; ol_nxt = 1'b1;
              if (rem_r == 7'd1) begin
                hcnt_nxt = '0;
                st_nxt = S_PAD;
              end
            end
          end else begin
            q_pop = 1'b1;
            if (wh_r == rt_r) begin
              ov_nxt = 1'b1; os_nxt = fmrb_pkg::ST_EMPTY;
              ob_nxt = '0; obv_nxt = 1'b0; ol_nxt = 1'b1;
            end else begin
              cap_nxt = q_cmd.byte_count;
              st_nxt = S_G0;
            end
          end
        end
      end
      S_HDR: begin
        we = 1'b1;
        wdata = (hcnt_r == '0) ? len_r : ((hcnt_r == HW'(1)) ? tot_r : 8'd0);
        if (hcnt_r == HW'(HEADER_BYTES)) begin
          // payload byte 0, or nothing for an empty message
          we = (len_r != 8'd0);
          wdata = d0_r;
          pp_nxt = (len_r != 8'd0) ? pp_r + 1'b1 : pp_r;
          q_pop = 1'b1;
          ov_nxt = 1'b1; os_nxt = fmrb_pkg::ST_OK;
          ob_nxt = '0; obv_nxt = 1'b0; ol_nxt = 1'b1;
          hcnt_nxt = '0;
          if (len_r <= 8'd1) begin
            st_nxt = S_PAD;
          end else begin
            rem_nxt = 7'(len_r - 8'd1);
            act_nxt = 1'b1;
            st_nxt = S_IDLE;
          end
        end else begin
          pp_nxt = pp_r + 1'b1;
          hcnt_nxt = hcnt_r + 1'b1;
        end
      end
      S_PAD: begin
        we = 1'b1; wdata = fmrb_pkg::PAD_BYTE;
        pp_nxt = pp_r + 1'b1;
        hcnt_nxt = hcnt_r + 1'b1;
        if (hcnt_r + 1'b1 == pad_r) begin
          wh_nxt = pp_r + 1'b1;
          act_nxt = 1'b0; rem_nxt = '0;
          st_nxt = S_IDLE;
        end
      end
      S_G0: begin
        raddr = rt_r;
        st_nxt = S_G1;
      end
      S_G1: begin
        raddr = rt_r + 1'b1;
        len_nxt = glen;
        st_nxt = S_G2;
      end
      S_G2: begin
        tot_nxt = rdata;
        raddr = rt_r + AW'(HEADER_BYTES);
        gi_nxt = '0;
        if (out_free) begin
          if (cap_r < 10'(len_r)) begin
            ov_nxt = 1'b1; os_nxt = fmrb_pkg::ST_SMALL;
            ob_nxt = '0; obv_nxt = 1'b0; ol_nxt = 1'b1;
            st_nxt = S_IDLE;
          end else if (len_r == 8'd0) begin
            ov_nxt = 1'b1; os_nxt = fmrb_pkg::ST_OK;
            ob_nxt = '0; obv_nxt = 1'b0; ol_nxt = 1'b1;
            rt_nxt = rt_r + AW'(rdata);
            st_nxt = S_IDLE;
          end else begin
            st_nxt = S_GB;
          end
        end else begin
          st_nxt = S_G3;
        end
      end
      S_G3: begin
        // hold the header read until the output register frees
        raddr = rt_r + AW'(HEADER_BYTES);
        if (out_free) begin
          if (cap_r < 10'(len_r)) begin
            ov_nxt = 1'b1; os_nxt = fmrb_pkg::ST_SMALL;
            ob_nxt = '0; obv_nxt = 1'b0; ol_nxt = 1'b1;
            st_nxt = S_IDLE;
          end else if (len_r == 8'd0) begin
            ov_nxt = 1'b1; os_nxt = fmrb_pkg::ST_OK;
            ob_nxt = '0; obv_nxt = 1'b0; ol_nxt = 1'b1;
            rt_nxt = rt_r + AW'(tot_r);
            st_nxt = S_IDLE;
          end else begin
            st_nxt = S_GB;
          end
        end
      end
      S_GB: begin
        // rdata holds byte gi; address for gi+1 issued only when it is taken
        raddr = rt_r + AW'(HEADER_BYTES) + AW'(gi_r);
        if (out_free) begin
          ov_nxt = 1'b1; os_nxt = fmrb_pkg::ST_OK;
          ob_nxt = rdata; obv_nxt = 1'b1;
          ol_nxt = (8'(gi_r) + 8'd1 == len_r);
          raddr = rt_r + AW'(HEADER_BYTES) + AW'(gi_r) + 1'b1;
          gi_nxt = gi_r + 1'b1;
          if (8'(gi_r) + 8'd1 == len_r) begin
            rt_nxt = rt_r + AW'(tot_r);
            st_nxt = S_IDLE;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; wh_r <= '0; rt_r <= '0; pp_r <= '0;
      rem_r <= '0; act_r <= 1'b0; drop_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; wh_r <= wh_nxt; rt_r <= rt_nxt; pp_r <= pp_nxt;
      rem_r <= rem_nxt; act_r <= act_nxt; drop_r <= drop_nxt; ov_r <= ov_nxt;
    end
    hcnt_r <= hcnt_nxt; pad_r <= pad_nxt; len_r <= len_nxt; tot_r <= tot_nxt;
    d0_r <= d0_nxt; cap_r <= cap_nxt; gi_r <= gi_nxt;
    os_r <= os_nxt; ob_r <= ob_nxt; obv_r <= obv_nxt; ol_r <= ol_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |=> (ov_r && $stable(os_r) && $stable(ob_r)))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n) act_r |-> !drop_r)
    else $error("active and dropping together");
  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE && st_r != S_PAD) |=> $stable(wh_r))
    else $error("write head moved outside commit");

endmodule

FILE: rtl/core/framed_message_ring_buffer_unit.sv
// Framed message ring buffer: stores length-framed messages (header, payload,
// 0xFF padding) in a byte ring memory. Later put bytes are written straight
// from decode; the first byte of an accepted message passes decode, the header
// bytes, then payload byte 0, and the last byte is followed by 1 to
// HEADER_BYTES padding bytes. A get decodes, reads the header in states G0 to
// G2, then sends one payload byte per cycle while the output is not stalled;
// the ring memory has a single read port. An empty-ring get answers from
// decode. A two-entry queue decouples input.
// depends on fmrb_pkg, fmrb_front, fmrb_back
module framed_message_ring_buffer_unit #(
  parameter int RING_BYTES   = fmrb_pkg::RING_BYTES_DEF,
  parameter int HEADER_BYTES = fmrb_pkg::HEADER_BYTES_DEF,
  parameter int MAX_MESSAGE  = fmrb_pkg::MAX_MESSAGE_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_func,
  input  logic [7:0] in_data_byte,
  input  logic       in_first_of_message,
  input  logic [9:0] in_byte_count,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_out_byte,
  output logic       out_byte_valid,
  output logic       out_last
);

  logic           q_valid, q_pop;
  fmrb_pkg::cmd_t q_cmd;

  fmrb_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_data_byte(in_data_byte),
    .in_first_of_message(in_first_of_message), .in_byte_count(in_byte_count),
    .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop)
  );

  fmrb_back #(
    .RING_BYTES(RING_BYTES), .HEADER_BYTES(HEADER_BYTES), .MAX_MESSAGE(MAX_MESSAGE)
  ) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_out_byte(out_out_byte), .out_byte_valid(out_byte_valid), .out_last(out_last)
  );

endmodule

FILE: tb/tb_top.sv
// testbench for framed_message_ring_buffer_unit: puts and gets of framed messages
// with random idling on both channels, checked against an in-bench ring predictor
// depends on fmrb_pkg and the framed_message_ring_buffer_unit RTL
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HDR       = fmrb_pkg::HEADER_BYTES_DEF;
  localparam int MAX_MSG   = fmrb_pkg::MAX_MESSAGE_DEF;
  localparam int RING      = fmrb_pkg::RING_BYTES_DEF;
  localparam int HOLD_LONG = 300;
  localparam int IDLE_MAX  = 2000;
  localparam int N_ITEMS   = 220;

  typedef struct {
    logic [1:0] status;
    logic [7:0] data;
    logic       vld;
    logic       last;
  } reply_t;

  class ring_scoreboard;
    logic [7:0] ring [RING];
    bit [9:0]   wr_head, rd_tail, put_pos;
    bit [6:0]   put_rem;
    bit         put_act, put_drop;
    reply_t     pending[$];
    int         errors, n_replies, n_rejects, n_deliveries;

    function int used_bytes();
      bit [9:0] u;
      u = wr_head - rd_tail;
      return int'(u);
    endfunction

    function int frame_bytes(int len);
      int t;
      t = HDR + len;
      return t + HDR - (t % HDR);
    endfunction

    function void store(logic [7:0] b);
      ring[put_pos] = b;
      put_pos++;
    endfunction

    function void commit();
      int len, pad;
      len = int'(ring[wr_head]);
      pad = frame_bytes(len) - HDR - len;
      for (int i = 0; i < pad; i++) store(fmrb_pkg::PAD_BYTE);
      wr_head = put_pos;
      put_act = 0;
      put_rem = 0;
    endfunction

    function void push(logic [1:0] st, logic [7:0] b, logic v, logic l);
      reply_t r;
      r.status = st; r.data = b; r.vld = v; r.last = l;
      pending.push_back(r);
      if (st == fmrb_pkg::ST_REJ) n_rejects++;
    endfunction

    function void note_request(logic f, logic [7:0] d, logic fst, logic [9:0] cnt);
      int total, len;
      bit [9:0] idx;
      if (f == fmrb_pkg::FUNC_PUT) begin
        if (fst) begin
          put_act = 0; put_drop = 0; put_rem = 0;
          total = frame_bytes(int'(cnt));
          if (cnt > MAX_MSG || total + 1 > RING - used_bytes()) begin
            put_drop = 1;
            push(fmrb_pkg::ST_REJ, 8'h00, 1'b0, 1'b1);
            return;
          end
          put_pos = wr_head;
          for (int i = 0; i < HDR; i++)
            store(i == 0 ? cnt[7:0] : (i == 1 ? total[7:0] : 8'h00));
          if (cnt == 0) commit();
          else begin
            store(d);
            put_rem = 7'(cnt - 10'd1);
            put_act = 1;
            if (put_rem == 0) commit();
          end
          push(fmrb_pkg::ST_OK, 8'h00, 1'b0, 1'b1);
        end else if (!put_act) begin
          push(fmrb_pkg::ST_REJ, 8'h00, 1'b0, 1'b1);
        end else begin
          store(d);
          put_rem--;
          if (put_rem == 0) commit();
          push(fmrb_pkg::ST_OK, 8'h00, 1'b0, 1'b1);
        end
      end else begin
        if (used_bytes() == 0) begin
          push(fmrb_pkg::ST_EMPTY, 8'h00, 1'b0, 1'b1);
          return;
        end
        idx = rd_tail + 10'd1;
        len = int'(ring[rd_tail]);
        total = int'(ring[idx]);
        if (len > MAX_MSG) len = MAX_MSG;
        if (cnt < len) begin
          push(fmrb_pkg::ST_SMALL, 8'h00, 1'b0, 1'b1);
          return;
        end
        if (len == 0) push(fmrb_pkg::ST_OK, 8'h00, 1'b0, 1'b1);
        idx = rd_tail + 10'(HDR);
        for (int i = 0; i < len; i++) begin
          push(fmrb_pkg::ST_OK, ring[idx], 1'b1, i + 1 == len);
          idx++;
        end
        n_deliveries++;
        rd_tail = rd_tail + 10'(total);
      end
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void check_result(logic [1:0] st, logic [7:0] b, logic v, logic l);
      reply_t e;
      n_replies++;
      if (pending.size() == 0) begin
        report($sformatf("result with none expected: st=%0d byte=%02h v=%0d last=%0d",
                         st, b, v, l));
        return;
      end
      e = pending.pop_front();
      if (st !== e.status || b !== e.data || v !== e.vld || l !== e.last)
        report($sformatf("got st=%0d byte=%02h v=%0d last=%0d, want %0d %02h %0d %0d",
                         st, b, v, l, e.status, e.data, e.vld, e.last));
    endfunction
  endclass

  logic       clk, rst_n;
  logic       in_valid, in_stall, in_func, in_first_of_message;
  logic [7:0] in_data_byte;
  logic [9:0] in_byte_count;
  logic       out_valid, out_stall, out_byte_valid, out_last;
  logic [1:0] out_status;
  logic [7:0] out_out_byte;

  ring_scoreboard sb = new();
  int  n_items, idle_cycles;
  bit  quiet, hold_req;

  framed_message_ring_buffer_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_data_byte(in_data_byte), .in_first_of_message(in_first_of_message),
    .in_byte_count(in_byte_count),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_out_byte(out_out_byte), .out_byte_valid(out_byte_valid), .out_last(out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send(logic f, logic [7:0] d, logic fst, logic [9:0] cnt);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_func <= f; in_data_byte <= d; in_first_of_message <= fst; in_byte_count <= cnt;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(f, d, fst, cnt);
    n_items++;
  endtask

  // stop_at < len abandons the message after that many bytes
  task automatic put_msg(int len, int stop_at = 1 << 20);
    send(fmrb_pkg::FUNC_PUT, 8'($urandom_range(0, 255)), 1'b1, 10'(len));
    for (int i = 1; i < len && i < stop_at; i++)
      send(fmrb_pkg::FUNC_PUT, 8'($urandom_range(0, 255)), 1'b0,
           10'($urandom_range(0, 1023)));
  endtask

  task automatic get_msg(int cap);
    send(fmrb_pkg::FUNC_GET, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
         10'(cap));
  endtask

  // receiver: random hold-off per request, one long hold when asked
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_LONG) @(posedge clk);
      end else begin
        n = quiet ? 0 : $urandom_range(0, 4);
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_status, out_out_byte, out_byte_valid, out_last);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_MAX) begin
      $display("timeout: no request moved for %0d cycles", IDLE_MAX);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    int len;
    rst_n <= 1'b0;
    in_valid <= 1'b0; in_func <= fmrb_pkg::FUNC_PUT; in_data_byte <= 8'h00;
    in_first_of_message <= 1'b0; in_byte_count <= 10'd0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty ring, empty message, small destination, extremes, rejects
    get_msg(1023);
    put_msg(0);
    get_msg(0);
    send(fmrb_pkg::FUNC_PUT, 8'hFF, 1'b1, 10'd1);
    get_msg(0);
    get_msg(1);
    send(fmrb_pkg::FUNC_PUT, 8'h00, 1'b0, 10'd0);             // stray byte
    send(fmrb_pkg::FUNC_PUT, 8'hA5, 1'b1, 10'(MAX_MSG + 1));  // too long
    send(fmrb_pkg::FUNC_PUT, 8'h5A, 1'b0, 10'd3);             // tail of the rejected one
    send(fmrb_pkg::FUNC_PUT, 8'hFF, 1'b1, 10'd1023);
    put_msg(5, 2);                                            // abandoned by the next first
    put_msg(3);
    get_msg(2);
    get_msg(3);
    put_msg(MAX_MSG);
    get_msg(MAX_MSG);
    get_msg(1023);

    // pressure: receiver held while small messages fill the ring to rejection
    quiet = 1'b1;
    hold_req = 1'b1;
    for (int i = 0; i < 70; i++) put_msg($urandom_range(0, 1));
    quiet = 1'b0;
    get_msg(0);

    // random mix; gets drain the full ring as they go
    while (n_items < N_ITEMS) begin
      quiet = ($urandom_range(0, 7) == 0);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: begin
          len = ($urandom_range(0, 5) == 0) ? $urandom_range(17, MAX_MSG)
                                            : $urandom_range(0, 16);
          if ($urandom_range(0, 9) == 0) put_msg(len, $urandom_range(1, len + 1));
          else put_msg(len);
        end
        9: put_msg($urandom_range(MAX_MSG + 1, 1023));
        10: send(fmrb_pkg::FUNC_PUT, 8'($urandom_range(0, 255)), 1'b0,
                 10'($urandom_range(0, 1023)));
        11, 12: get_msg($urandom_range(0, 1023));
        default: get_msg($urandom_range(0, 20));
      endcase
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.pending.size() != 0) sb.report("results still expected at end of run");

    $display("requests %0d, results %0d, rejected puts %0d, messages delivered %0d",
             n_items, sb.n_replies, sb.n_rejects, sb.n_deliveries);
    $display("covered empty, short, full-length and abandoned messages, ring full, stalls");
    if (sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule

FILE: framed_message_ring_buffer_unit.f
rtl/core/fmrb_pkg.sv
rtl/core/fmrb_ram.sv
rtl/core/fmrb_front.sv
rtl/core/fmrb_back.sv
rtl/core/framed_message_ring_buffer_unit.sv
tb/tb_top.sv
